[hdl/dss_pkg.sv]
// Shared types and constants for the dual stack shared memory block.
// Used by the controller, the datapath and the top level.
package dss_pkg;

  localparam int VALUE_W = 32;
  localparam int SIZE_W  = 7;
  localparam int HOME_W  = 6;

  localparam logic [SIZE_W-1:0] SIZE_RST = 7'd64;
  localparam logic [HOME_W-1:0] HOME_RST = 6'd31;

  // configuration register indexes
  localparam logic CFG_SIZE = 1'b0;
  localparam logic CFG_HOME = 1'b1;

  // operation and stack select codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;
  localparam logic SEL_ONE = 1'b0;
  localparam logic SEL_TWO = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  typedef struct packed {
    logic exec;     // act on the input beat this cycle
    logic capture;  // load RAM read data into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // output register empty or being drained
    logic need_read;  // current beat is a pop that reads memory
  } dp_stat_t;

endpackage

[hdl/dual_stack_shared_memory.sv]
// Two stacks in one shared memory with a movable soft boundary.
// Timing: a push or an empty pop goes straight to the output register; a pop that reads
// memory goes through the registered RAM read first. One push or empty pop per cycle;
// a reading pop blocks input until captured, and a held output beat stalls the input.
// Reset: pointers, boundary, configuration and output valid return to reset values;
// the memory contents are not cleared, so no item waits on a clearing pass.
// Depends on dss_pkg, dss_ctrl, dss_dp and dss_ram.
module dual_stack_shared_memory
  import dss_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [SIZE_W-1:0]  cfg_wdata,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]         in_tuser,   // [0] kind, [1] stack_sel
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,  // [31:0] pop_value
  output logic [1:0]         out_tuser   // [1:0] status
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  dss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dss_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

[hdl/dss_ram.sv]
// Generic RAM: one write port, one read port, registered read data.
// No dependencies.
module dss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/dss_ctrl.sv]
// Controller for the dual stack block: accepts beats, waits out the RAM read.
// Depends on dss_pkg.
module dss_ctrl
  import dss_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    cmd.exec    = 1'b0;
    cmd.capture = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = stat.out_free;
        cmd.exec  = in_tvalid && stat.out_free;
        if (cmd.exec && stat.need_read) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        // read data is valid now
        cmd.capture = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

[hdl/dss_dp.sv]
// Datapath for the dual stack block: config, pointers, boundary, RAM, output register.
// Depends on dss_pkg and dss_ram.
module dss_dp
  import dss_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [SIZE_W-1:0]  cfg_wdata,
  input  logic [1:0]         in_tuser,
  input  logic [VALUE_W-1:0] in_tdata,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [VALUE_W-1:0] out_tdata,
  output logic [1:0]         out_tuser,
  input  ctrl_cmd_t          cmd,
  output dp_stat_t           stat
);

  localparam int AW = $clog2(DEPTH);
  localparam int TW = AW + 1;                  // top index, -1 .. DEPTH-1
  localparam int CW = $clog2(DEPTH + 1);       // count, 0 .. DEPTH
  localparam int SW = ((AW > SIZE_W) ? AW : SIZE_W) + 3;
  localparam logic signed [SW-1:0] DEPTH_S = SW'(DEPTH);
  localparam logic signed [SW-1:0] ONE_S   = SW'(1);

  logic [SIZE_W-1:0]        size_r;
  logic [HOME_W-1:0]        home_r;
  logic signed [TW-1:0]     top_one_r;
  logic [CW-1:0]            count_two_r;
  logic signed [SW-1:0]     shift_r;
  logic                     out_valid_r;
  logic [VALUE_W-1:0]       out_data_r;
  status_t                  out_status_r;
  logic                     rd_zero_r;

  logic signed [SW-1:0] size_s, eff_s, home_s, top_s, cnt_s, b_s, t2_s;
  logic signed [SW-1:0] nxt1_s, nxt2_s, topm1_s;
  logic                 kind, sel;
  logic                 below_b, fast2, room1, room2, empty1, empty2, t2_ok;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [VALUE_W-1:0]   ram_rdata;

  assign kind = in_tuser[0];
  assign sel  = in_tuser[1];

  assign size_s  = SW'(size_r);
  assign eff_s   = (size_s > DEPTH_S) ? DEPTH_S : size_s;
  assign home_s  = SW'(home_r);
  assign top_s   = SW'(top_one_r);
  assign cnt_s   = SW'(count_two_r);
  assign b_s     = home_s + shift_r;
  assign t2_s    = eff_s - cnt_s;
  assign nxt1_s  = top_s + ONE_S;
  assign nxt2_s  = t2_s - ONE_S;
  assign topm1_s = top_s - ONE_S;

  assign below_b = top_s < b_s;
  assign fast2   = t2_s > b_s + ONE_S;
  assign room1   = (nxt1_s < t2_s) && (nxt1_s >= 0) && (nxt1_s < DEPTH_S);
  assign room2   = (nxt2_s > top_s) && (nxt2_s >= 0) && (nxt2_s < DEPTH_S);
  assign empty1  = top_s < 0;
  assign empty2  = count_two_r == '0;
  assign t2_ok   = (t2_s >= 0) && (t2_s < DEPTH_S);

  assign stat.out_free  = !out_valid_r || out_tready;
  assign stat.need_read = (kind == OP_POP) && ((sel == SEL_ONE) ? !empty1 : !empty2);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = (sel == SEL_ONE) ? nxt1_s[AW-1:0] : nxt2_s[AW-1:0];
    ram_raddr = (sel == SEL_ONE) ? top_s[AW-1:0] : t2_s[AW-1:0];
    if (cmd.exec && kind == OP_PUSH) begin
      ram_we = (sel == SEL_ONE) ? ((below_b || fast2) && room1)
                                : ((fast2 || below_b) && room2);
    end
  end

  dss_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r      <= SIZE_RST;
      home_r      <= HOME_RST;
      top_one_r   <= '1;
      count_two_r <= '0;
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_SIZE: size_r <= cfg_wdata;
          CFG_HOME: home_r <= cfg_wdata[HOME_W-1:0];
          default:  ;
        endcase
      end

      if (cmd.exec) begin
        priority if (kind == OP_PUSH && sel == SEL_ONE) begin
          if ((below_b || fast2) && room1) begin
            top_one_r <= nxt1_s[TW-1:0];
            if (!below_b) shift_r <= shift_r + ONE_S;   // borrow a slot
          end
        end else if (kind == OP_PUSH) begin
          if ((fast2 || below_b) && room2) begin
            count_two_r <= count_two_r + CW'(1);
            if (!fast2) shift_r <= shift_r - ONE_S;
          end
        end else if (sel == SEL_ONE) begin
          if (!empty1) begin
            top_one_r <= topm1_s[TW-1:0];
            if (b_s > home_s) shift_r <= shift_r - ONE_S;
          end
        end else begin
          if (!empty2) begin
            count_two_r <= count_two_r - CW'(1);
            if (b_s <= home_s) shift_r <= shift_r + ONE_S;
          end
        end
      end

      if (cmd.exec && !stat.need_read) begin
        out_valid_r <= 1'b1;
      end else if (cmd.capture) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      rd_zero_r <= (sel == SEL_TWO) && !t2_ok;
      if (kind == OP_PUSH) begin
        out_data_r   <= '0;
        out_status_r <= ((sel == SEL_ONE) ? ((below_b || fast2) && room1)
                                          : ((fast2 || below_b) && room2))
                        ? ST_OK : ST_FULL;
      end else if (!stat.need_read) begin
        out_data_r   <= '1;
        out_status_r <= ST_EMPTY;
      end
    end else if (cmd.capture) begin
      out_data_r   <= rd_zero_r ? '0 : ram_rdata;
      out_status_r <= ST_OK;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

[verif/stack_result_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for dual_stack_shared_memory: follows register writes and input beats,
// predicts the result of each operation and compares it with the output beats.
// Depends on dss_pkg.
module stack_result_checker
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [SIZE_W-1:0]  cfg_wdata,
  input  logic               in_tvalid,
  input  logic               in_tready,
  input  logic [VALUE_W-1:0] in_tdata,   // [31:0] push_value
  input  logic [1:0]         in_tuser,   // [0] kind, [1] stack_sel
  input  logic               out_tvalid,
  input  logic               out_tready,
  input  logic [VALUE_W-1:0] out_tdata,  // [31:0] pop_value
  input  logic [1:0]         out_tuser,  // [1:0] status
  output int                 fails,
  output int                 pending
);

  localparam int MEM_WORDS = 64;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    status_t            status;
  } stack_result_t;

  logic [VALUE_W-1:0] words [MEM_WORDS];
  int                 top_one;
  int                 count_two;
  int                 shift;
  logic [SIZE_W-1:0]  size_reg;
  logic [HOME_W-1:0]  home_reg;
  stack_result_t      expected_results [$];
  int                 err_count = 0;

  function automatic stack_result_t predict_stack_op(logic kind, logic sel,
                                                     logic [VALUE_W-1:0] val);
    stack_result_t res;
    int  home, b, sz, t2, nxt;
    bit  room, go, borrow;
    res.value  = '0;
    res.status = ST_OK;
    home = int'(home_reg);
    b    = home + shift;
    sz   = (int'(size_reg) > MEM_WORDS) ? MEM_WORDS : int'(size_reg);
    t2   = sz - count_two;
    if (kind == OP_PUSH) begin
      if (sel == SEL_ONE) begin
        nxt    = top_one + 1;
        room   = nxt < t2 && nxt >= 0 && nxt < MEM_WORDS;
        go     = top_one < b || t2 > b + 1;
        borrow = !(top_one < b) && t2 > b + 1;
        if (go && room) begin
          if (borrow) shift++;
          top_one    = nxt;
          words[nxt] = val;
        end else begin
          res.status = ST_FULL;
        end
      end else begin
        nxt    = t2 - 1;
        room   = nxt > top_one && nxt >= 0 && nxt < MEM_WORDS;
        go     = t2 > b + 1 || top_one < b;
        borrow = !(t2 > b + 1) && top_one < b;
        if (go && room) begin
          if (borrow) shift--;
          count_two++;
          words[nxt] = val;
        end else begin
          res.status = ST_FULL;
        end
      end
    end else if (sel == SEL_ONE) begin
      if (top_one < 0) begin
        res.value  = '1;
        res.status = ST_EMPTY;
      end else begin
        if (b > home) shift--;
        res.value = (top_one < MEM_WORDS) ? words[top_one] : '0;
        top_one--;
      end
    end else begin
      if (count_two <= 0) begin
        res.value  = '1;
        res.status = ST_EMPTY;
      end else begin
        if (b <= home) shift++;
        // stack two's top may sit outside the memory after a size change
        res.value = (t2 >= 0 && t2 < MEM_WORDS) ? words[t2] : '0;
        count_two--;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    stack_result_t exp_r;
    if (!rst_n) begin
      top_one   = -1;
      count_two = 0;
      shift     = 0;
      size_reg  = SIZE_RST;
      home_reg  = HOME_RST;
      expected_results.delete();
    end else begin
      // results leave before the beat accepted at the same edge can produce one
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result beat: pop_value %0d, status %0d",
                 $signed(out_tdata), out_tuser);
          err_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_tdata !== exp_r.value) begin
            $error("pop_value: expected %0d, got %0d",
                   $signed(exp_r.value), $signed(out_tdata));
            err_count++;
          end
          if (out_tuser !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
            err_count++;
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_SIZE) size_reg = cfg_wdata;
        else home_reg = cfg_wdata[HOME_W-1:0];
      end
      if (in_tvalid && in_tready)
        expected_results.push_back(predict_stack_op(in_tuser[0], in_tuser[1], in_tdata));
    end
    fails   <= err_count;
    pending <= expected_results.size();
  end

endmodule

[verif/tb_dual_stack_shared_memory.sv]
`timescale 1ns / 1ps
// Top of the dual_stack_shared_memory testbench: clock, reset, register writes,
// push/pop stimulus and output backpressure. Depends on dss_pkg and stack_result_checker.
module tb_dual_stack_shared_memory;
  import dss_pkg::*;

  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 55;
  localparam int HOLD_CYCLES = 80;
  // a zero size picks a random size and home
  localparam int PHASE_SIZE [PHASES] = '{2, 64, 127, 5, 64, 0, 0, 0};
  localparam int PHASE_HOME [PHASES] = '{0, 63, 31, 40, 0, 0, 0, 0};

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic               cfg_addr = CFG_SIZE;
  logic [SIZE_W-1:0]  cfg_wdata = '0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [VALUE_W-1:0] in_tdata = '0;   // [31:0] push_value
  logic [1:0]         in_tuser = '0;   // [0] kind, [1] stack_sel
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [VALUE_W-1:0] out_tdata;       // [31:0] pop_value
  logic [1:0]         out_tuser;       // [1:0] status

  logic steady = 1'b0;
  logic hold_req = 1'b0;
  logic hold_taken = 1'b0;
  int   hold_left = 0;
  int   fails;
  int   pending;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  dual_stack_shared_memory u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  stack_result_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fails      (fails),
    .pending    (pending)
  );

  // one long hold-off on request, otherwise random stalls unless steady
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || $urandom_range(0, 99) >= 33;
    end
  end

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // hold valid until the beat is taken; valid stays high into the next call
  task automatic send_op(input logic kind, input logic sel, input logic [VALUE_W-1:0] val);
    while (!steady && $urandom_range(0, 99) < 33) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= val;
    in_tuser  <= {sel, kind};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic set_config(input int size_val, input int home_val);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_SIZE;
    cfg_wdata <= SIZE_W'(size_val);
    @(posedge clk);
    cfg_addr  <= CFG_HOME;
    cfg_wdata <= SIZE_W'(home_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int i, p, size_val, home_val, push_pct;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // pops on empty stacks
    send_op(OP_POP, SEL_ONE, '0);
    send_op(OP_POP, SEL_TWO, '1);
    // stack one runs past home by borrowing, stack two fills the rest: every word
    // gets written here, so no later pop reads an unwritten word
    for (i = 0; i < 40; i++) send_op(OP_PUSH, SEL_ONE, pick_value());
    for (i = 0; i < 25; i++) send_op(OP_PUSH, SEL_TWO, pick_value());
    send_op(OP_PUSH, SEL_ONE, pick_value());
    // drain both; the pops walk the boundary back and past home
    for (i = 0; i < 41; i++) send_op(OP_POP, SEL_ONE, $urandom);
    for (i = 0; i < 25; i++) send_op(OP_POP, SEL_TWO, $urandom);

    // shrink the memory under live data: stack two's top falls below zero and
    // pushes hit the collision guard with home beyond the size
    for (i = 0; i < 5; i++) send_op(OP_PUSH, SEL_TWO, pick_value());
    for (i = 0; i < 2; i++) send_op(OP_PUSH, SEL_ONE, pick_value());
    wait_drained();
    set_config(2, 31);
    send_op(OP_PUSH, SEL_ONE, pick_value());
    send_op(OP_PUSH, SEL_TWO, pick_value());
    for (i = 0; i < 6; i++) send_op(OP_POP, SEL_TWO, $urandom);
    for (i = 0; i < 3; i++) send_op(OP_POP, SEL_ONE, $urandom);
    // size above the memory clamps to its depth
    wait_drained();
    set_config(127, 0);
    send_op(OP_PUSH, SEL_ONE, pick_value());
    send_op(OP_PUSH, SEL_TWO, pick_value());
    send_op(OP_POP, SEL_ONE, $urandom);
    send_op(OP_POP, SEL_TWO, $urandom);

    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      size_val = (PHASE_SIZE[p] != 0) ? PHASE_SIZE[p] : $urandom_range(2, 64);
      home_val = (PHASE_SIZE[p] != 0) ? PHASE_HOME[p] : $urandom_range(0, 63);
      set_config(size_val, home_val);
      push_pct = $urandom_range(35, 75);
      steady <= (p == 1 || p == 5);
      if (p == 1) hold_req <= 1'b1;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) wait_drained();
        send_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                $urandom_range(0, 1) ? SEL_TWO : SEL_ONE, pick_value());
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
hdl/dss_pkg.sv
hdl/dss_ram.sv
hdl/dss_ctrl.sv
hdl/dss_dp.sv
hdl/dual_stack_shared_memory.sv
verif/stack_result_checker.sv
verif/tb_dual_stack_shared_memory.sv
